@@ hdl/otsu_pkg.sv @@
// Shared types and constants for the Otsu threshold block.
// No dependencies; imported by the top level and its checker.
package otsu_pkg;

   // histogram geometry
   localparam int PIXEL_W   = 8;
   localparam int HIST_BINS = 256;

   // main sequencer states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_COUNT,
      ST_SCAN_RD,
      ST_SCAN_CNT,
      ST_MUL,
      ST_MUL_WAIT,
      ST_NEXT,
      ST_OUT
   } state_type;

   // which product the shared multiplier is working on for the current bin
   typedef enum logic [2:0] {
      PH_MOM,
      PH_A,
      PH_B,
      PH_DEN,
      PH_DSQ,
      PH_LHS,
      PH_RHS
   } phase_type;

endpackage

@@ hdl/otsu_mul.sv @@
// Shift-add multiplier shared by every product of the threshold scan.
// One conditional add per cycle; stops as soon as the multiplier runs out of ones.
// No package dependencies.
module otsu_mul #(
   parameter int PW = 124,
   parameter int BW = 44
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [PW-1:0] mcand,
   input  logic [BW-1:0] mplier,
   output logic [PW-1:0] product,
   output logic          done
);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [PW-1:0] acc_ff, acc_in;
   logic [PW-1:0] mcand_ff, mcand_in;
   logic [BW-1:0] mplier_ff, mplier_in;

   // load on start, then add and shift until the multiplier is empty
   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      if (start) begin
         busy_in   = 1'b1;
         acc_in    = '0;
         mcand_in  = mcand;
         mplier_in = mplier;
      end else if (busy_ff) begin
         if (mplier_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            if (mplier_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in  = {mcand_ff[PW-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[BW-1:1]};
         end
      end
   end

   // control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign product = acc_ff;
   assign done    = done_ff;

endmodule

@@ hdl/otsu_threshold.sv @@
// Otsu threshold top level: histogram memory, frame totals and the scan sequencer.
// Depends on otsu_pkg and otsu_mul.
//
// Usage:
//   req_ channel carries one pixel word (req_pixel) and req_last, which marks
//   the final pixel of a frame. rsp_ channel returns one word, rsp_threshold,
//   per frame, the first bin with the largest between-class variance.
//   A pixel word is read from its histogram bin, then written back as count+1.
//   After the last pixel the block scans bins 0 to 255. Each bin needs one
//   memory read and up to seven products on a shift-add multiplier that
//   retires one multiplier bit a cycle. Bins are zeroed as they are scanned.
//   req_ready is high only while waiting for a pixel; it stays low through
//   the scan and while the threshold word waits on rsp_ready, which may
//   stall indefinitely with rsp_threshold held.
//   After reset a clearing pass zeroes the 256 histogram entries, one per
//   cycle, before req_ready first rises.
//   Pixels beyond MAX_PIXELS in a frame are dropped; req_last still ends it.
module otsu_threshold
   import otsu_pkg::*;
#(
   parameter int MAX_PIXELS = 131072
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [PIXEL_W-1:0] req_pixel,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [PIXEL_W-1:0] rsp_threshold
);

   // count, sum, product widths
   localparam int CW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS + 1) : 1;
   localparam int UW = CW + PIXEL_W;
   localparam int DW = 2 * CW + PIXEL_W;
   localparam int NW = 2 * CW;
   localparam int SW = 2 * DW;
   localparam int PW = SW + NW;
   localparam int BW = DW;

   localparam logic [CW-1:0]      MAX_N    = CW'(MAX_PIXELS);
   localparam logic [PIXEL_W-1:0] LAST_BIN = PIXEL_W'(HIST_BINS - 1);

   state_type          state_ff, state_in;
   phase_type          phase_ff, phase_in;
   logic [PIXEL_W-1:0] bin_ff, bin_in;
   logic [PIXEL_W-1:0] pix_ff, pix_in;
   logic               last_ff, last_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [CW-1:0]      n_ff, n_in;
   logic [UW-1:0]      u_ff, u_in;
   logic [CW-1:0]      w_ff, w_in;
   logic [UW-1:0]      m_ff, m_in;
   logic [DW-1:0]      a_ff, a_in;
   logic [DW-1:0]      d_ff, d_in;
   logic [NW-1:0]      den_ff, den_in;
   logic [SW-1:0]      dsq_ff, dsq_in;
   logic [PW-1:0]      lhs_ff, lhs_in;
   logic [SW-1:0]      bestsq_ff, bestsq_in;
   logic [NW-1:0]      bestden_ff, bestden_in;
   logic [PIXEL_W-1:0] bestbin_ff, bestbin_in;

   logic [CW-1:0]      hist_mem [HIST_BINS];
   logic [CW-1:0]      rd_data_ff;
   logic               mem_we;
   logic [PIXEL_W-1:0] mem_waddr;
   logic [CW-1:0]      mem_wdata;
   logic [PIXEL_W-1:0] mem_raddr;

   logic               mul_start;
   logic [PW-1:0]      mul_a;
   logic [BW-1:0]      mul_b;
   logic [PW-1:0]      mul_prod;
   logic               mul_done;
   logic [DW-1:0]      prod_d;

   assign prod_d = mul_prod[DW-1:0];

   otsu_mul #(
      .PW(PW),
      .BW(BW)
   ) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .mcand  (mul_a),
      .mplier (mul_b),
      .product(mul_prod),
      .done   (mul_done)
   );

   // histogram memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= hist_mem[mem_raddr];
   end

   // sequencer: next state, datapath updates, memory and multiplier control
   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      bin_in     = bin_ff;
      pix_in     = pix_ff;
      last_in    = last_ff;
      cnt_in     = cnt_ff;
      n_in       = n_ff;
      u_in       = u_ff;
      w_in       = w_ff;
      m_in       = m_ff;
      a_in       = a_ff;
      d_in       = d_ff;
      den_in     = den_ff;
      dsq_in     = dsq_ff;
      lhs_in     = lhs_ff;
      bestsq_in  = bestsq_ff;
      bestden_in = bestden_ff;
      bestbin_in = bestbin_ff;
      mem_we     = 1'b0;
      mem_waddr  = bin_ff;
      mem_wdata  = '0;
      mem_raddr  = bin_ff;
      mul_start  = 1'b0;
      mul_a      = '0;
      mul_b      = '0;
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            // zero one bin per cycle after reset
            mem_we = 1'b1;
            if (bin_ff == LAST_BIN) begin
               bin_in   = '0;
               state_in = ST_IDLE;
            end else begin
               bin_in = bin_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            // take a pixel word and start reading its bin
            req_ready = 1'b1;
            mem_raddr = req_pixel;
            if (req_valid) begin
               pix_in   = req_pixel;
               last_in  = req_last;
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            // bump the bin unless the frame is full
            mem_waddr = pix_ff;
            mem_wdata = rd_data_ff + 1'b1;
            if (n_ff < MAX_N) begin
               mem_we = 1'b1;
               n_in   = n_ff + 1'b1;
               u_in   = u_ff + UW'(pix_ff);
            end
            if (last_ff) begin
               bin_in     = '0;
               w_in       = '0;
               m_in       = '0;
               bestsq_in  = '0;
               bestden_in = NW'(1);
               bestbin_in = '0;
               state_in   = ST_SCAN_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CNT;
         end
         ST_SCAN_CNT: begin
            // accumulate weight, zero the bin for the next frame
            cnt_in   = rd_data_ff;
            w_in     = w_ff + rd_data_ff;
            mem_we   = 1'b1;
            phase_in = PH_MOM;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // issue the product for the current phase
            mul_start = 1'b1;
            state_in  = ST_MUL_WAIT;
            unique case (phase_ff)
               PH_MOM: begin
                  mul_a = PW'(bin_ff);
                  mul_b = BW'(cnt_ff);
               end
               PH_A: begin
                  mul_a = PW'(u_ff);
                  mul_b = BW'(w_ff);
               end
               PH_B: begin
                  mul_a = PW'(m_ff);
                  mul_b = BW'(n_ff);
               end
               PH_DEN: begin
                  mul_a = PW'(w_ff);
                  mul_b = BW'(n_ff - w_ff);
               end
               PH_DSQ: begin
                  mul_a = PW'(d_ff);
                  mul_b = d_ff;
               end
               PH_LHS: begin
                  mul_a = PW'(dsq_ff);
                  mul_b = BW'(bestden_ff);
               end
               PH_RHS: begin
                  mul_a = PW'(bestsq_ff);
                  mul_b = BW'(den_ff);
               end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
         end
         ST_MUL_WAIT: begin
            // retire the product and pick the next step
            if (mul_done) begin
               state_in = ST_MUL;
               unique case (phase_ff)
                  PH_MOM: begin
                     m_in = m_ff + mul_prod[UW-1:0];
                     if (w_ff == '0 || w_ff >= n_ff) begin
                        state_in = ST_NEXT;
                     end else begin
                        phase_in = PH_A;
                     end
                  end
                  PH_A: begin
                     a_in     = prod_d;
                     phase_in = PH_B;
                  end
                  PH_B: begin
                     d_in     = (a_ff > prod_d) ? (a_ff - prod_d) : (prod_d - a_ff);
                     phase_in = PH_DEN;
                  end
                  PH_DEN: begin
                     den_in   = mul_prod[NW-1:0];
                     phase_in = PH_DSQ;
                  end
                  PH_DSQ: begin
                     dsq_in   = mul_prod[SW-1:0];
                     phase_in = PH_LHS;
                  end
                  PH_LHS: begin
                     lhs_in   = mul_prod;
                     phase_in = PH_RHS;
                  end
                  PH_RHS: begin
                     if (lhs_ff > mul_prod) begin
                        bestsq_in  = dsq_ff;
                        bestden_in = den_ff;
                        bestbin_in = bin_ff;
                     end
                     state_in = ST_NEXT;
                  end
                  default: begin
                     state_in = ST_NEXT;
                  end
               endcase
            end
         end
         ST_NEXT: begin
            // advance to the next bin or finish the scan
            if (bin_ff == LAST_BIN) begin
               state_in = ST_OUT;
            end else begin
               bin_in   = bin_ff + 1'b1;
               state_in = ST_SCAN_RD;
            end
         end
         ST_OUT: begin
            // hold the threshold word until taken, then reset the frame totals
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               n_in       = '0;
               u_in       = '0;
               bestbin_in = '0;
               bin_in     = '0;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         bin_ff     <= '0;
         n_ff       <= '0;
         u_ff       <= '0;
         bestbin_ff <= '0;
      end else begin
         state_ff   <= state_in;
         bin_ff     <= bin_in;
         n_ff       <= n_in;
         u_ff       <= u_in;
         bestbin_ff <= bestbin_in;
      end
   end

   // scan datapath
   always_ff @(posedge clock) begin
      phase_ff   <= phase_in;
      pix_ff     <= pix_in;
      last_ff    <= last_in;
      cnt_ff     <= cnt_in;
      w_ff       <= w_in;
      m_ff       <= m_in;
      a_ff       <= a_in;
      d_ff       <= d_in;
      den_ff     <= den_in;
      dsq_ff     <= dsq_in;
      lhs_ff     <= lhs_in;
      bestsq_ff  <= bestsq_in;
      bestden_ff <= bestden_in;
   end

   assign rsp_threshold = bestbin_ff;

endmodule

@@ hdl/otsu_checker.sv @@
// Port-level checker for otsu_threshold, attached by the bind at the end.
// Depends on otsu_pkg.
module otsu_port_props
   import otsu_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_last,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [PIXEL_W-1:0] rsp_threshold
);

   // never take a pixel while a threshold word is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("req_ready and rsp_valid high together");

   // an accepted pixel word always takes req_ready low while the block handles it
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req_ready high right after an accepted word");

   // a non-final pixel never produces a threshold word
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_last) |=> !rsp_valid)
      else $error("threshold word after a non-final pixel");

   // a stalled threshold word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_threshold)))
      else $error("threshold word dropped or changed under stall");

   // once the threshold word is taken the block waits for the next frame
   a_idle_after_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> (req_ready && !rsp_valid))
      else $error("block not ready after threshold word");

endmodule

bind otsu_threshold otsu_port_props u_otsu_port_props (.*);
